// ===== rtl/core/dedup_message_fifo_assert.svh =====
// Assertion macros for the duplicate-suppressing message FIFO.
// Included by dmf_ctrl, which checks its own control state.
`ifndef DEDUP_MESSAGE_FIFO_ASSERT_SVH
`define DEDUP_MESSAGE_FIFO_ASSERT_SVH

`ifndef SYNTH
`define DMF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DMF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DMF_ASSERT_IMP(lbl, ante, cons, msg)
`define DMF_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/dmf_pkg.sv =====
// Types and constants shared by the duplicate-suppressing message FIFO.
// No dependencies.
package dmf_pkg;

  localparam int unsigned BYTE_DEPTH = 4096;
  localparam int unsigned BYTE_AW    = $clog2(BYTE_DEPTH);
  localparam int unsigned USED_W     = $clog2(BYTE_DEPTH + 1);
  localparam int unsigned SUM_W      = USED_W + 1;
  localparam int unsigned MSG_DEPTH  = 64;
  localparam int unsigned MSG_AW     = $clog2(MSG_DEPTH);
  localparam int unsigned CNT_W      = $clog2(MSG_DEPTH + 1);
  localparam int unsigned MAX_LEN    = 255;
  localparam int unsigned LEN_W      = 8;
  localparam int unsigned LEN1_W     = LEN_W + 1;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_TAKEN  = 3'd0,
    ST_STORED = 3'd1,
    ST_REPEAT = 3'd2,
    ST_FULL   = 3'd3,
    ST_POPPED = 3'd4,
    ST_EMPTY  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_PUSH,
    CS_POP,
    CS_HEAD
  } ctrl_state_e;

  typedef struct packed {
    logic              operation;
    logic [7:0]        data_in;
    logic              last_in;
    logic signed [7:0] rssi_in;
    logic              check_repeat;
  } in_req_t;

  typedef struct packed {
    status_e           status;
    logic [7:0]        data_out;
    logic              last_out;
    logic [7:0]        msg_length;
    logic signed [7:0] msg_rssi;
    logic signed [7:0] head_rssi;
    logic              queue_empty;
  } out_rsp_t;

  typedef struct packed {
    logic [BYTE_AW-1:0] start;
    logic [LEN_W-1:0]   len;
    logic signed [7:0]  rssi;
  } desc_t;

  localparam int unsigned DESC_W = $bits(desc_t);

  typedef struct packed {
    logic               we;
    logic [BYTE_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [BYTE_AW-1:0] raddr;
  } bmem_req_t;

  typedef struct packed {
    logic              we;
    logic [MSG_AW-1:0] waddr;
    desc_t             wdata;
    logic              re;
    logic [MSG_AW-1:0] raddr;
  } dmem_req_t;

endpackage

// ===== rtl/core/dmf_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module dmf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dmf_ctrl.sv =====
// Sequencer of the message FIFO: push compare and write, pop and head refill.
// Depends on dmf_pkg and dedup_message_fifo_assert.svh.
`include "dedup_message_fifo_assert.svh"
module dmf_ctrl import dmf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_req_t     in_req_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output out_rsp_t    res_o,
  output bmem_req_t   bmem_req_o,
  input  logic [7:0]  bmem_rdata_i,
  output dmem_req_t   dmem_req_o,
  input  desc_t       dmem_rdata_i
);

  ctrl_state_e        state_q, state_d;
  in_req_t            req_q, req_d;
  logic [MSG_AW-1:0]  head_idx_q, head_idx_d;
  logic [MSG_AW-1:0]  tail_idx_q, tail_idx_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [BYTE_AW-1:0] bwp_q, bwp_d;
  logic [USED_W-1:0]  used_q, used_d;
  logic [LEN_W-1:0]   stage_len_q, stage_len_d;
  logic               match_q, match_d;
  logic               ovf_q, ovf_d;
  logic [LEN_W-1:0]   pop_off_q, pop_off_d;
  logic [BYTE_AW-1:0] newest_start_q, newest_start_d;
  logic [LEN_W-1:0]   newest_len_q, newest_len_d;
  desc_t              head_desc_q, head_desc_d;
  out_rsp_t           res_q, res_d;

  logic               accept;
  logic               has_room;
  logic               match_n;
  logic               ovf_n;
  logic [LEN_W-1:0]   len_n;
  logic               push_full;
  logic               push_repeat;
  logic               push_store;
  logic               pop_nonempty;
  logic               pop_last;
  logic               pop_refill;

  assign in_ready_o = (state_q == CS_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign has_room = (stage_len_q < LEN_W'(MAX_LEN)) &&
                    (SUM_W'(used_q) + SUM_W'(stage_len_q) + SUM_W'(1) <= SUM_W'(BYTE_DEPTH));
  assign match_n  = match_q && (count_q != '0) && (stage_len_q < newest_len_q) &&
                    (bmem_rdata_i == req_q.data_in);
  assign ovf_n    = ovf_q || !has_room;
  assign len_n    = has_room ? stage_len_q + LEN_W'(1) : stage_len_q;

  assign push_full   = req_q.last_in && (ovf_n || (count_q >= CNT_W'(MSG_DEPTH)));
  assign push_repeat = req_q.last_in && !push_full && req_q.check_repeat && match_n &&
                       (count_q != '0);
  assign push_store  = req_q.last_in && !push_full && !push_repeat;

  assign pop_nonempty = (count_q != '0);
  assign pop_last     = (LEN1_W'(pop_off_q) + LEN1_W'(1)) >= LEN1_W'(head_desc_q.len);
  assign pop_refill   = (state_q == CS_POP) && pop_nonempty && pop_last &&
                        (count_q != CNT_W'(1));

  assign res_valid_o = (state_q == CS_PUSH) || (state_q == CS_HEAD) ||
                       ((state_q == CS_POP) && !pop_refill);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: begin
        if (accept) begin
          state_d = (in_req_i.operation == OP_POP) ? CS_POP : CS_PUSH;
        end
      end
      CS_PUSH: begin
        if (res_ready_i) begin
          state_d = CS_IDLE;
        end
      end
      CS_POP: begin
        if (pop_refill) begin
          state_d = CS_HEAD;
        end else if (res_ready_i) begin
          state_d = CS_IDLE;
        end
      end
      CS_HEAD: begin
        if (res_ready_i) begin
          state_d = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    req_d          = req_q;
    head_idx_d     = head_idx_q;
    tail_idx_d     = tail_idx_q;
    count_d        = count_q;
    bwp_d          = bwp_q;
    used_d         = used_q;
    stage_len_d    = stage_len_q;
    match_d        = match_q;
    ovf_d          = ovf_q;
    pop_off_d      = pop_off_q;
    newest_start_d = newest_start_q;
    newest_len_d   = newest_len_q;
    head_desc_d    = head_desc_q;
    res_d          = res_q;
    bmem_req_o     = '0;
    dmem_req_o     = '0;
    res_o          = '0;
    res_o.head_rssi   = '1;
    res_o.queue_empty = 1'b1;

    unique case (state_q)
      CS_IDLE: begin
        if (accept) begin
          req_d         = in_req_i;
          bmem_req_o.re = 1'b1;
          if (in_req_i.operation == OP_POP) begin
            bmem_req_o.raddr = head_desc_q.start + BYTE_AW'(pop_off_q);
          end else begin
            bmem_req_o.raddr = newest_start_q + BYTE_AW'(stage_len_q);
          end
        end
      end

      CS_PUSH: begin
        res_o.status = push_full ? ST_FULL : push_repeat ? ST_REPEAT :
                       push_store ? ST_STORED : ST_TAKEN;
        res_o.queue_empty = !(push_store || pop_nonempty);
        if (push_store && !pop_nonempty) begin
          res_o.head_rssi = req_q.rssi_in;
        end else if (pop_nonempty) begin
          res_o.head_rssi = head_desc_q.rssi;
        end
        if (res_ready_i) begin
          if (has_room) begin
            bmem_req_o.we    = 1'b1;
            bmem_req_o.waddr = bwp_q + BYTE_AW'(stage_len_q);
            bmem_req_o.wdata = req_q.data_in;
          end
          if (req_q.last_in) begin
            stage_len_d = '0;
            match_d     = 1'b1;
            ovf_d       = 1'b0;
            if (push_store) begin
              dmem_req_o.we          = 1'b1;
              dmem_req_o.waddr       = tail_idx_q;
              dmem_req_o.wdata.start = bwp_q;
              dmem_req_o.wdata.len   = len_n;
              dmem_req_o.wdata.rssi  = req_q.rssi_in;
              tail_idx_d     = tail_idx_q + MSG_AW'(1);
              count_d        = count_q + CNT_W'(1);
              used_d         = used_q + USED_W'(len_n);
              bwp_d          = bwp_q + BYTE_AW'(len_n);
              newest_start_d = bwp_q;
              newest_len_d   = len_n;
              if (!pop_nonempty) begin
                head_desc_d = dmem_req_o.wdata;
              end
            end
          end else begin
            stage_len_d = len_n;
            match_d     = match_n;
            ovf_d       = ovf_n;
          end
        end
      end

      CS_POP: begin
        if (!pop_nonempty) begin
          res_o.status = ST_EMPTY;
        end else begin
          res_o.status      = ST_POPPED;
          res_o.data_out    = bmem_rdata_i;
          res_o.last_out    = pop_last;
          res_o.msg_length  = head_desc_q.len;
          res_o.msg_rssi    = head_desc_q.rssi;
          res_o.queue_empty = 1'b0;
          res_o.head_rssi   = head_desc_q.rssi;
          if (pop_last) begin
            res_o.queue_empty = !pop_refill;
            res_o.head_rssi   = '1;
            if (pop_refill || res_ready_i) begin
              head_idx_d = head_idx_q + MSG_AW'(1);
              count_d    = count_q - CNT_W'(1);
              used_d     = (used_q >= USED_W'(head_desc_q.len)) ?
                           used_q - USED_W'(head_desc_q.len) : '0;
              pop_off_d  = '0;
            end
            if (pop_refill) begin
              dmem_req_o.re    = 1'b1;
              dmem_req_o.raddr = head_idx_q + MSG_AW'(1);
              res_d            = res_o;
            end
          end else if (res_ready_i) begin
            pop_off_d = pop_off_q + LEN_W'(1);
          end
        end
      end

      CS_HEAD: begin
        res_o             = res_q;
        res_o.head_rssi   = dmem_rdata_i.rssi;
        res_o.queue_empty = 1'b0;
        if (res_ready_i) begin
          head_desc_d = dmem_rdata_i;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      head_idx_q  <= '0;
      tail_idx_q  <= '0;
      count_q     <= '0;
      bwp_q       <= '0;
      used_q      <= '0;
      stage_len_q <= '0;
      match_q     <= 1'b1;
      ovf_q       <= 1'b0;
      pop_off_q   <= '0;
    end else begin
      state_q     <= state_d;
      head_idx_q  <= head_idx_d;
      tail_idx_q  <= tail_idx_d;
      count_q     <= count_d;
      bwp_q       <= bwp_d;
      used_q      <= used_d;
      stage_len_q <= stage_len_d;
      match_q     <= match_d;
      ovf_q       <= ovf_d;
      pop_off_q   <= pop_off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q          <= req_d;
    newest_start_q <= newest_start_d;
    newest_len_q   <= newest_len_d;
    head_desc_q    <= head_desc_d;
    res_q          <= res_d;
  end

  `DMF_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(MSG_DEPTH), "message count overflow")
  `DMF_ASSERT_IMP(a_ring_span, 1'b1, (tail_idx_q - head_idx_q) == count_q[MSG_AW-1:0],
                  "ring indexes disagree with message count")
  `DMF_ASSERT_IMP(a_used_bound, 1'b1, used_q <= USED_W'(BYTE_DEPTH), "byte store overcommitted")
  `DMF_ASSERT_IMP(a_empty_pop, res_valid_o && (res_o.status == ST_EMPTY), count_q == '0,
                  "empty pop reported with messages stored")
  `DMF_ASSERT_NXT(a_refill_seq, pop_refill, state_q == CS_HEAD,
                  "head refill did not follow the last byte of a message")

endmodule

// ===== rtl/core/dedup_message_fifo.sv =====
// Message FIFO with repeat suppression: byte store and descriptor ring in RAM.
// Results enter the output register when it can take them, from CS_PUSH or CS_POP, or
// from CS_HEAD for a pop that ends a message while another stays queued. Requests are
// taken only in CS_IDLE, none before the last result is handed on; each waits on a
// registered byte-store read, that pop also on a descriptor read. Reset clears control
// state only; the memories stay uninitialized and need no clearing pass. Uses dmf_pkg.
module dedup_message_fifo import dmf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_rsp_o
);

  bmem_req_t  bmem_req;
  logic [7:0] bmem_rdata;
  dmem_req_t  dmem_req;
  desc_t      dmem_rdata;
  logic       res_valid;
  logic       res_ready;
  out_rsp_t   res;
  logic       out_valid_q, out_valid_d;
  out_rsp_t   out_rsp_q, out_rsp_d;

  dmf_ram #(
    .WIDTH (8),
    .DEPTH (BYTE_DEPTH)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (bmem_req.we),
    .waddr_i (bmem_req.waddr),
    .wdata_i (bmem_req.wdata),
    .re_i    (bmem_req.re),
    .raddr_i (bmem_req.raddr),
    .rdata_o (bmem_rdata)
  );

  dmf_ram #(
    .WIDTH (DESC_W),
    .DEPTH (MSG_DEPTH)
  ) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (dmem_req.we),
    .waddr_i (dmem_req.waddr),
    .wdata_i (dmem_req.wdata),
    .re_i    (dmem_req.re),
    .raddr_i (dmem_req.raddr),
    .rdata_o (dmem_rdata)
  );

  dmf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .bmem_req_o   (bmem_req),
    .bmem_rdata_i (bmem_rdata),
    .dmem_req_o   (dmem_req),
    .dmem_rdata_i (dmem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_rsp_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
